// ===== rtl/core/resol_pkg.sv =====
`timescale 1ns / 1ps

package resol_pkg;

  // Field widths fixed by the item format
  localparam int unsigned AddrW    = 32;
  localparam int unsigned LenW     = 16;
  localparam int unsigned TargetW  = 20;
  localparam int unsigned SlotOutW = 4;

  // Default ring depth
  localparam int unsigned SlotCountDef = 16;

  // Item action codes
  typedef enum logic {
    ACT_ADD  = 1'b0,
    ACT_FIND = 1'b1
  } action_e;

  // Walk sequencer states
  typedef enum logic {
    WK_IDLE = 1'b0,
    WK_RUN  = 1'b1
  } walk_state_e;

  // Walk outcome handed to the top level
  typedef struct packed {
    logic            done;
    logic            hit;
    logic [LenW-1:0] offset;
  } walk_status_t;

endpackage

// ===== rtl/core/resol_walk.sv =====
`timescale 1ns / 1ps

module resol_walk #(
  parameter int unsigned SLOT_COUNT = resol_pkg::SlotCountDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [$clog2(SLOT_COUNT)-1:0]      first_idx_i,
  input  logic [$clog2(SLOT_COUNT+1)-1:0]    count_i,
  input  logic [resol_pkg::TargetW-1:0]      target_i,
  output logic                               rd_en_o,
  output logic [$clog2(SLOT_COUNT)-1:0]      rd_addr_o,
  input  logic [resol_pkg::AddrW-1:0]        rd_address_i,
  input  logic [resol_pkg::LenW-1:0]         rd_length_i,
  output logic [$clog2(SLOT_COUNT)-1:0]      hit_idx_o,
  output resol_pkg::walk_status_t            status_o,
  output logic                               busy_o
);
  import resol_pkg::*;

  localparam int unsigned IdxW = $clog2(SLOT_COUNT);
  localparam int unsigned CntW = $clog2(SLOT_COUNT + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOT_COUNT - 1);

  walk_state_e         state_q, state_d;
  logic [IdxW-1:0]     ptr_q;
  logic [CntW-1:0]     left_q;
  logic                pend_q;
  logic [IdxW-1:0]     pend_idx_q;
  logic [TargetW-1:0]  total_q;
  logic [TargetW-1:0]  target_q;

  logic                issue;
  logic [TargetW:0]    sum;
  logic                live;
  logic                hit;
  logic                miss;
  logic [TargetW-1:0]  offset;

  // Shared accumulate and compare unit; a read left over from a finished walk counts for nothing
  always_comb begin
    live   = (state_q == WK_RUN) && pend_q && (rd_address_i != '0);
    sum    = {1'b0, total_q} + (TargetW + 1)'(rd_length_i);
    hit    = live && (sum > {1'b0, target_q});
    offset = target_q - total_q;
  end

  // Issue one slot read a cycle while entries remain
  always_comb begin
    issue = (state_q == WK_RUN) && (left_q != '0);
    miss  = (state_q == WK_RUN) && !pend_q && (left_q == '0);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      WK_IDLE: if (start_i) state_d = WK_RUN;
      WK_RUN:  if (hit || miss) state_d = WK_IDLE;
      default: state_d = WK_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    rd_en_o         = issue;
    rd_addr_o       = ptr_q;
    hit_idx_o       = pend_idx_q;
    busy_o          = (state_q == WK_RUN);
    status_o.done   = hit || miss;
    status_o.hit    = hit;
    status_o.offset = offset[LenW-1:0];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= WK_IDLE;
      left_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == WK_IDLE && start_i) begin
        left_q <= count_i;
        pend_q <= 1'b0;
      end else begin
        pend_q <= issue;
        if (issue) left_q <= left_q - CntW'(1);
      end
    end
  end

  // Walk pointer and running total
  always_ff @(posedge clk_i) begin
    if (state_q == WK_IDLE && start_i) begin
      ptr_q    <= first_idx_i;
      total_q  <= '0;
      target_q <= target_i;
    end else begin
      if (issue) begin
        ptr_q      <= (ptr_q == LastIdx) ? '0 : ptr_q + IdxW'(1);
        pend_idx_q <= ptr_q;
      end
      if (live && !hit) total_q <= sum[TargetW-1:0];
    end
  end

  // Checks
  a_rd_only_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_o |-> busy_o)
    else $error("slot read issued outside a walk");

  a_total_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> total_q <= target_q)
    else $error("running total passed the target without a hit");

  a_done_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.done |=> !busy_o)
    else $error("walk did not stop after its outcome");

endmodule

// ===== rtl/core/ring_entry_store_offset_lookup_unit.sv =====
`timescale 1ns / 1ps

// Channel  | Direction | Handshake              | Ports
// ---------+-----------+------------------------+-------------------------------------------
// item     | in        | start && !busy         | action_i entry_address_i entry_length_i
//          |           |                        | char_offset_i
// result   | out       | result_valid_o strobe  | found_o slot_index_o found_address_o
//          |           |                        | found_length_o byte_offset_o
//
// An add's result strobes in the next cycle and busy stays low.
// A find walks one slot a cycle through the single read port of the slot memory,
// and busy stays high until the walk ends; a hit ends it early, an empty ring
// ends it with a miss, and the result strobes in the cycle busy falls.
// Reset clears the pointers and the full flag; the slot memory is not swept, as a
// walk only ever reaches slots already written. The receiver cannot stall results.
module ring_entry_store_offset_lookup_unit #(
  parameter int unsigned SLOT_COUNT = resol_pkg::SlotCountDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            action_i,
  input  logic [resol_pkg::AddrW-1:0]     entry_address_i,
  input  logic [resol_pkg::LenW-1:0]      entry_length_i,
  input  logic [resol_pkg::TargetW-1:0]   char_offset_i,
  output logic                            result_valid_o,
  output logic                            found_o,
  output logic [resol_pkg::SlotOutW-1:0]  slot_index_o,
  output logic [resol_pkg::AddrW-1:0]     found_address_o,
  output logic [resol_pkg::LenW-1:0]      found_length_o,
  output logic [resol_pkg::LenW-1:0]      byte_offset_o
);
  import resol_pkg::*;

  localparam int unsigned IdxW = $clog2(SLOT_COUNT);
  localparam int unsigned CntW = $clog2(SLOT_COUNT + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOT_COUNT - 1);

  // Slot memory
  logic [AddrW-1:0]    slot_addr_mem [SLOT_COUNT];
  logic [LenW-1:0]     slot_len_mem  [SLOT_COUNT];
  logic [AddrW-1:0]    rd_address_q;
  logic [LenW-1:0]     rd_length_q;

  logic [IdxW-1:0]     wp_q, rp_q;
  logic                full_q;
  logic [IdxW-1:0]     wp_next, rp_next;

  logic                accept, do_add, do_find;
  logic [CntW:0]       span;
  logic [CntW-1:0]     count;

  logic                rd_en;
  logic [IdxW-1:0]     rd_addr;
  logic [IdxW-1:0]     hit_idx;
  walk_status_t        status;
  logic                walk_busy;

  logic                     valid_q;
  logic                     found_q;
  logic [IdxW-1:0]          slot_q;
  logic [AddrW-1:0]         addr_out_q;
  logic [LenW-1:0]          len_out_q;
  logic [LenW-1:0]          off_out_q;
  logic [SlotOutW+IdxW-1:0] slot_wide;

  // Accept and decode
  always_comb begin
    accept  = start && !walk_busy;
    do_add  = accept && (action_i == ACT_ADD);
    do_find = accept && (action_i == ACT_FIND);
    wp_next = (wp_q == LastIdx) ? '0 : wp_q + IdxW'(1);
    rp_next = (rp_q == LastIdx) ? '0 : rp_q + IdxW'(1);
  end

  // Live slot count for a walk
  always_comb begin
    if (wp_q >= rp_q) begin
      span = (CntW + 1)'(wp_q) - (CntW + 1)'(rp_q);
    end else begin
      span = (CntW + 1)'(wp_q) + (CntW + 1)'(SLOT_COUNT) - (CntW + 1)'(rp_q);
    end
    count = full_q ? CntW'(SLOT_COUNT) : span[CntW-1:0];
  end

  // Write one slot per add
  always_ff @(posedge clk_i) begin
    if (do_add) begin
      slot_addr_mem[wp_q] <= entry_address_i;
      slot_len_mem[wp_q]  <= entry_length_i;
    end
  end

  // Registered slot read for the walk
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_address_q <= slot_addr_mem[rd_addr];
      rd_length_q  <= slot_len_mem[rd_addr];
    end
  end

  // Advance pointers; drop the oldest entry once full
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      full_q <= 1'b0;
    end else if (do_add) begin
      wp_q <= wp_next;
      if (full_q) rp_q <= rp_next;
      if (wp_next == (full_q ? rp_next : rp_q)) full_q <= 1'b1;
    end
  end

  resol_walk #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (do_find),
    .first_idx_i  (rp_q),
    .count_i      (count),
    .target_i     (char_offset_i),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_address_i (rd_address_q),
    .rd_length_i  (rd_length_q),
    .hit_idx_o    (hit_idx),
    .status_o     (status),
    .busy_o       (walk_busy)
  );

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      found_q <= 1'b0;
    end else begin
      valid_q <= do_add || status.done;
      if (do_add || status.done) found_q <= !do_add && status.hit;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (do_add) begin
      slot_q     <= wp_q;
      addr_out_q <= '0;
      len_out_q  <= '0;
      off_out_q  <= '0;
    end else if (status.done) begin
      if (status.hit) begin
        slot_q     <= hit_idx;
        addr_out_q <= rd_address_q;
        len_out_q  <= rd_length_q;
        off_out_q  <= status.offset;
      end else begin
        slot_q     <= '0;
        addr_out_q <= '0;
        len_out_q  <= '0;
        off_out_q  <= '0;
      end
    end
  end

  always_comb begin
    slot_wide       = (SlotOutW + IdxW)'(slot_q);
    busy            = walk_busy;
    result_valid_o  = valid_q;
    found_o         = found_q;
    slot_index_o    = slot_wide[SlotOutW-1:0];
    found_address_o = addr_out_q;
    found_length_o  = len_out_q;
    byte_offset_o   = off_out_q;
  end

  // Checks
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !found_o) |->
      (found_address_o == '0 && found_length_o == '0 && byte_offset_o == '0))
    else $error("non-hit result carries payload");

  a_hit_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && found_o) |->
      (byte_offset_o < found_length_o && found_address_o != '0))
    else $error("hit offset outside entry");

  a_full_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |=> full_q)
    else $error("full flag cleared");

  a_rp_before_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full_q |-> rp_q == '0)
    else $error("read pointer moved before ring filled");

endmodule

// ===== verif/resol_lookup_checker.sv =====
`timescale 1ns / 1ps

module resol_lookup_checker #(
  parameter int unsigned SLOT_COUNT = resol_pkg::SlotCountDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            busy_i,
  input  logic                            action_i,
  input  logic [resol_pkg::AddrW-1:0]     entry_address_i,
  input  logic [resol_pkg::LenW-1:0]      entry_length_i,
  input  logic [resol_pkg::TargetW-1:0]   char_offset_i,
  input  logic                            result_valid_i,
  input  logic                            found_i,
  input  logic [resol_pkg::SlotOutW-1:0]  slot_index_i,
  input  logic [resol_pkg::AddrW-1:0]     found_address_i,
  input  logic [resol_pkg::LenW-1:0]      found_length_i,
  input  logic [resol_pkg::LenW-1:0]      byte_offset_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_count_o,
  output int unsigned                     hit_count_o
);

  typedef struct packed {
    logic                           found;
    logic [resol_pkg::SlotOutW-1:0] slot;
    logic [resol_pkg::AddrW-1:0]    addr;
    logic [resol_pkg::LenW-1:0]     len;
    logic [resol_pkg::LenW-1:0]     offset;
  } lookup_t;

  // Shadow copy of the ring
  logic [resol_pkg::AddrW-1:0] ring_addr [SLOT_COUNT];
  logic [resol_pkg::LenW-1:0]  ring_len  [SLOT_COUNT];
  int unsigned                 wr_ptr;
  int unsigned                 rd_ptr;
  logic                        ring_full;

  lookup_t pending_lookups [$];
  lookup_t want;
  lookup_t got;

  // Apply one item to the shadow ring and work out the result it causes
  task automatic lookup_predict(input  logic                          act,
                                input  logic [resol_pkg::AddrW-1:0]   addr,
                                input  logic [resol_pkg::LenW-1:0]    len,
                                input  logic [resol_pkg::TargetW-1:0] target,
                                output lookup_t                       res);
    int unsigned idx;
    int unsigned walk_len;
    int unsigned total;
    res = '0;
    if (act == resol_pkg::ACT_ADD) begin
      // Write at the write pointer; a full ring drops its oldest entry
      res.slot          = wr_ptr[resol_pkg::SlotOutW-1:0];
      ring_addr[wr_ptr] = addr;
      ring_len[wr_ptr]  = len;
      wr_ptr            = (wr_ptr + 1) % SLOT_COUNT;
      if (ring_full) begin
        rd_ptr = (rd_ptr + 1) % SLOT_COUNT;
      end
      if (wr_ptr == rd_ptr) begin
        ring_full = 1'b1;
      end
    end else begin
      // Walk oldest to newest, skipping empty slots, until the offset is covered
      idx      = rd_ptr;
      walk_len = ring_full ? SLOT_COUNT : (wr_ptr + SLOT_COUNT - rd_ptr) % SLOT_COUNT;
      total    = 0;
      for (int unsigned k = 0; k < walk_len && !res.found; k++) begin
        if (ring_addr[idx] != '0) begin
          if (total + 32'(ring_len[idx]) > 32'(target)) begin
            res.found  = 1'b1;
            res.slot   = idx[resol_pkg::SlotOutW-1:0];
            res.addr   = ring_addr[idx];
            res.len    = ring_len[idx];
            res.offset = resol_pkg::LenW'(32'(target) - total);
          end else begin
            total = total + 32'(ring_len[idx]);
          end
        end
        idx = (idx + 1) % SLOT_COUNT;
      end
    end
  endtask

  // Check results against the oldest expectation, then predict the accepted item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < SLOT_COUNT; i++) begin
        ring_addr[i] = '0;
        ring_len[i]  = '0;
      end
      wr_ptr    = 0;
      rd_ptr    = 0;
      ring_full = 1'b0;
      pending_lookups.delete();
      fail_count_o    = 0;
      pending_count_o = 0;
      hit_count_o     = 0;
    end else begin
      if (result_valid_i) begin
        got = '{found_i, slot_index_i, found_address_i, found_length_i, byte_offset_i};
        if (got.found) begin
          hit_count_o = hit_count_o + 1;
        end
        if (pending_lookups.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("[%0t] result with nothing expected: found=%0b slot=%0d addr=%h len=%0d off=%0d",
                     $realtime, got.found, got.slot, got.addr, got.len, got.offset);
          end
          fail_count_o = fail_count_o + 1;
        end else begin
          want = pending_lookups.pop_front();
          if (got != want) begin
            if (fail_count_o < 10) begin
              $display("[%0t] mismatch: expected found=%0b slot=%0d addr=%h len=%0d off=%0d",
                       $realtime, want.found, want.slot, want.addr, want.len, want.offset);
              $display("[%0t]           actual   found=%0b slot=%0d addr=%h len=%0d off=%0d",
                       $realtime, got.found, got.slot, got.addr, got.len, got.offset);
            end
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      if (start_i && !busy_i) begin
        lookup_predict(action_i, entry_address_i, entry_length_i, char_offset_i, want);
        pending_lookups.push_back(want);
      end
      pending_count_o = pending_lookups.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned SLOT_COUNT  = resol_pkg::SlotCountDef;
  localparam int unsigned ITEM_COUNT  = 1750;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                           clk_i           = 1'b0;
  logic                           rst_ni          = 1'b0;
  logic                           start           = 1'b0;
  logic                           action_i        = resol_pkg::ACT_ADD;
  logic [resol_pkg::AddrW-1:0]    entry_address_i = '0;
  logic [resol_pkg::LenW-1:0]     entry_length_i  = '0;
  logic [resol_pkg::TargetW-1:0]  char_offset_i   = '0;
  logic                           busy;
  logic                           result_valid_o;
  logic                           found_o;
  logic [resol_pkg::SlotOutW-1:0] slot_index_o;
  logic [resol_pkg::AddrW-1:0]    found_address_o;
  logic [resol_pkg::LenW-1:0]     found_length_o;
  logic [resol_pkg::LenW-1:0]     byte_offset_o;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned hit_count;
  int unsigned adds_sent  = 0;
  int unsigned finds_sent = 0;
  int unsigned cycle_count = 0;

  always #6 clk_i = ~clk_i;

  ring_entry_store_offset_lookup_unit #(
    .SLOT_COUNT(SLOT_COUNT)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .entry_address_i(entry_address_i),
    .entry_length_i (entry_length_i),
    .char_offset_i  (char_offset_i),
    .result_valid_o (result_valid_o),
    .found_o        (found_o),
    .slot_index_o   (slot_index_o),
    .found_address_o(found_address_o),
    .found_length_o (found_length_o),
    .byte_offset_o  (byte_offset_o)
  );

  resol_lookup_checker #(
    .SLOT_COUNT(SLOT_COUNT)
  ) lookup_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .action_i       (action_i),
    .entry_address_i(entry_address_i),
    .entry_length_i (entry_length_i),
    .char_offset_i  (char_offset_i),
    .result_valid_i (result_valid_o),
    .found_i        (found_o),
    .slot_index_i   (slot_index_o),
    .found_address_i(found_address_o),
    .found_length_i (found_length_o),
    .byte_offset_i  (byte_offset_o),
    .fail_count_o   (fail_count),
    .pending_count_o(pending_count),
    .hit_count_o    (hit_count)
  );

  // Present one item and hold it until the block takes it
  task automatic send_item(input logic                          act,
                           input logic [resol_pkg::AddrW-1:0]   addr,
                           input logic [resol_pkg::LenW-1:0]    len,
                           input logic [resol_pkg::TargetW-1:0] off);
    start           <= 1'b1;
    action_i        <= act;
    entry_address_i <= addr;
    entry_length_i  <= len;
    char_offset_i   <= off;
    @(posedge clk_i);
    while (busy) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
    if (act == resol_pkg::ACT_ADD) begin
      adds_sent = adds_sent + 1;
    end else begin
      finds_sent = finds_sent + 1;
    end
  endtask

  // Drop start for a number of cycles; zero keeps items back to back
  task automatic idle_gap(input int unsigned cycles);
    if (cycles != 0) begin
      start <= 1'b0;
      repeat (cycles) @(negedge clk_i);
    end
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      return 0;
    end else if (roll < 88) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 40);
  endfunction

  // Build a random item: small lengths and offsets keep finds landing on entries
  task automatic random_item();
    resol_pkg::action_e            act;
    logic [resol_pkg::AddrW-1:0]   addr;
    logic [resol_pkg::LenW-1:0]    len;
    logic [resol_pkg::TargetW-1:0] off;
    int unsigned                   roll;
    act  = ($urandom_range(0, 99) < 48) ? resol_pkg::ACT_ADD : resol_pkg::ACT_FIND;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      addr = '0;
    end else if (roll < 15) begin
      addr = '1;
    end else begin
      addr = $urandom();
    end
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      len = '0;
    end else if (roll < 75) begin
      len = resol_pkg::LenW'($urandom_range(1, 40));
    end else if (roll < 80) begin
      len = '1;
    end else begin
      len = resol_pkg::LenW'($urandom_range(0, 65535));
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      off = resol_pkg::TargetW'($urandom_range(0, 700));
    end else if (roll < 67) begin
      off = '0;
    end else if (roll < 72) begin
      off = '1;
    end else begin
      off = resol_pkg::TargetW'($urandom_range(0, 1048575));
    end
    send_item(act, addr, len, off);
  endtask

  // Stop a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count = cycle_count + 1;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("status: fail");
    $finish;
  end

  initial begin
    int unsigned burst_left;
    burst_left = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty ring, one maximal entry, then empty and zero-length slots
    send_item(resol_pkg::ACT_FIND, '0, '0, '0);
    idle_gap(pick_gap());
    send_item(resol_pkg::ACT_FIND, '1, '1, '1);
    idle_gap(pick_gap());
    send_item(resol_pkg::ACT_ADD, '1, '1, '0);
    send_item(resol_pkg::ACT_FIND, '0, '0, '0);
    send_item(resol_pkg::ACT_FIND, '0, '0, 20'd65535);
    idle_gap(pick_gap());
    send_item(resol_pkg::ACT_FIND, '0, '0, 20'd65536);
    send_item(resol_pkg::ACT_ADD, '0, 16'd100, '0);
    send_item(resol_pkg::ACT_ADD, 32'h1234_5678, '0, '0);
    idle_gap(pick_gap());
    send_item(resol_pkg::ACT_ADD, 32'hA5A5_0001, 16'd10, '1);
    send_item(resol_pkg::ACT_FIND, '0, '0, 20'd65536);
    send_item(resol_pkg::ACT_FIND, '0, '0, 20'd65545);
    idle_gap(pick_gap());
    send_item(resol_pkg::ACT_FIND, '0, '0, 20'd65546);
    idle_gap(pick_gap());

    // Random: the ring fills, wraps and overwrites; bursts run without gaps
    for (int unsigned n = 0; n < ITEM_COUNT; n++) begin
      random_item();
      if (burst_left != 0) begin
        burst_left = burst_left - 1;
      end else if ($urandom_range(0, 199) == 0) begin
        burst_left = $urandom_range(20, 50);
      end else begin
        idle_gap(pick_gap());
      end
    end
    start <= 1'b0;

    // Drain outstanding results, then allow one more walk to surface stray strobes
    while (pending_count != 0) begin
      @(negedge clk_i);
    end
    repeat (SLOT_COUNT + 4) @(negedge clk_i);

    $display("ran %0d adds and %0d finds (%0d hits, %0d misses) over a %0d-slot ring",
             adds_sent, finds_sent, hit_count, finds_sent - hit_count, SLOT_COUNT);
    $display("ring wrapped about %0d times; %0d results failed", adds_sent / SLOT_COUNT,
             fail_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
